// ===== hdl/tssf_pkg.sv =====
package tssf_pkg;

    // Sizing of the cell row and of the column range
    localparam int QUERY_MAX  = 64;
    localparam int COLUMNS    = 1024;
    localparam int CELL_IDX_W = $clog2(QUERY_MAX);

    typedef logic        [7:0]            char_t;
    typedef logic signed [15:0]           row_t;
    typedef logic        [9:0]            col_t;
    typedef logic        [10:0]           ecol_t;
    typedef logic        [15:0]           cnt_t;
    typedef logic        [6:0]            qlen_t;
    typedef logic        [5:0]            slot_t;
    typedef logic        [CELL_IDX_W-1:0] cell_idx_t;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_TEXT    = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    // Broadcast from the input side to every cell
    typedef struct packed {
        logic  text_en;     // text item accepted this cycle
        logic  clr;         // restart item accepted this cycle
        char_t ch;
        logic  row_change;  // row differs from the previous text item
        row_t  row;
        col_t  col;
    } bcast_t;

    // Partial match state handed from one cell to the next
    typedef struct packed {
        logic hit;          // a prefix of the query ends at the newest text item
        logic brk;          // that prefix already crosses one row change
        row_t start_row;
        col_t start_col;
    } link_t;

endpackage

// ===== hdl/tssf_cell.sv =====
module tssf_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  tssf_pkg::bcast_t bus,
    input  logic             head,      // first cell: no row change before it
    input  logic             q_we,
    input  tssf_pkg::char_t  q_wdata,
    input  tssf_pkg::link_t  link_in,
    output tssf_pkg::link_t  link_out
);

    tssf_pkg::char_t q_reg;
    logic            hit_reg, hit_next;
    logic            brk_reg, brk_next;
    tssf_pkg::row_t  srow_reg, srow_next;
    tssf_pkg::col_t  scol_reg, scol_next;
    logic            chg;

    // Extend the upstream prefix by one character
    always_comb begin
        chg       = bus.row_change & ~head;
        hit_next  = hit_reg;
        brk_next  = brk_reg;
        srow_next = srow_reg;
        scol_next = scol_reg;
        if (bus.clr) begin
            hit_next = 1'b0;
        end else if (bus.text_en) begin
            hit_next  = link_in.hit && (bus.ch == q_reg) && !(link_in.brk && chg);
            brk_next  = link_in.brk | chg;
            srow_next = link_in.start_row;
            scol_next = link_in.start_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        brk_reg  <= brk_next;
        srow_reg <= srow_next;
        scol_reg <= scol_next;
        if (q_we) begin
            q_reg <= q_wdata;
        end
    end

    assign link_out = '{hit: hit_reg, brk: brk_reg, start_row: srow_reg,
                        start_col: scol_reg};

endmodule

// ===== hdl/text_stream_substring_finder.sv =====
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   action, char_code, query_slot, text_row, text_col
// m_       out        m_valid / m_ready   start_row, start_col, end_row, end_col, match_number
// cfg_     in         cfg_we (no wait)    query_length
//
// A text item updates the cell row at its accept edge and sets the pending
// bit; once the output register is free, cell query_length-1 is selected into
// it. Text items flow at one per cycle while m_ready stays
// high; the single result register between the cell row and m_ is what sets it.
// A held result stalls input only while a selection is pending behind it.
// Reset clears the match flags, counter, pending bit and output valid; the
// query characters stay undefined until loaded.
module text_stream_substring_finder (
    input  logic                  aclk,
    input  logic                  aresetn,
    // query length register
    input  logic                  cfg_we,
    input  tssf_pkg::qlen_t       cfg_wdata,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  tssf_pkg::char_t       s_char_code,
    input  tssf_pkg::slot_t       s_query_slot,
    input  tssf_pkg::row_t        s_text_row,
    input  tssf_pkg::col_t        s_text_col,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output tssf_pkg::row_t        m_start_row,
    output tssf_pkg::col_t        m_start_col,
    output tssf_pkg::row_t        m_end_row,
    output tssf_pkg::ecol_t       m_end_col,
    output tssf_pkg::cnt_t        m_match_number
);

    // --- config: clamped length, kept as the index of the final cell ---
    tssf_pkg::cell_idx_t sel_reg, sel_next;
    logic                len_nz_reg, len_nz_next;

    always_comb begin
        len_nz_next = len_nz_reg;
        sel_next    = sel_reg;
        if (cfg_we) begin
            len_nz_next = (cfg_wdata != '0);
            if (int'(cfg_wdata) > tssf_pkg::QUERY_MAX) begin
                sel_next = tssf_pkg::cell_idx_t'(tssf_pkg::QUERY_MAX - 1);
            end else begin
                sel_next = tssf_pkg::cell_idx_t'(cfg_wdata - 7'd1);
            end
        end
    end

    // --- input decode ---
    logic              s_acc;
    logic              text_acc, load_acc, restart_acc;
    tssf_pkg::col_t    col_sat;
    tssf_pkg::row_t    last_row_reg, last_row_next;
    tssf_pkg::col_t    last_col_reg, last_col_next;
    tssf_pkg::bcast_t  bus;

    assign s_acc = s_valid && s_ready;

    always_comb begin
        text_acc    = 1'b0;
        load_acc    = 1'b0;
        restart_acc = 1'b0;
        unique case (tssf_pkg::action_t'(s_action))
            tssf_pkg::ACT_LOAD:    load_acc    = s_acc;
            tssf_pkg::ACT_TEXT:    text_acc    = s_acc;
            tssf_pkg::ACT_RESTART: restart_acc = s_acc;
            default: ;  // unused code: item is dropped
        endcase
    end

    // Columns past the row width pin to the last column
    assign col_sat = (int'(s_text_col) >= tssf_pkg::COLUMNS)
                   ? tssf_pkg::col_t'(tssf_pkg::COLUMNS - 1) : s_text_col;

    assign bus = '{text_en: text_acc, clr: restart_acc, ch: s_char_code,
                   row_change: (s_text_row != last_row_reg),
                   row: s_text_row, col: col_sat};

    assign last_row_next = text_acc ? s_text_row : last_row_reg;
    assign last_col_next = text_acc ? col_sat    : last_col_reg;

    // --- cell row: cell k flags a match of query[0..k] ending at the newest text ---
    tssf_pkg::link_t links [tssf_pkg::QUERY_MAX+1];

    // Virtual empty prefix in front of cell 0; starts at the current character
    assign links[0] = '{hit: 1'b1, brk: 1'b0, start_row: s_text_row, start_col: col_sat};

    for (genvar k = 0; k < tssf_pkg::QUERY_MAX; k++) begin : g_cell
        tssf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .bus      (bus),
            .head     (k == 0),
            .q_we     (load_acc && (int'(s_query_slot) == k)),
            .q_wdata  (s_char_code),
            .link_in  (links[k]),
            .link_out (links[k+1])
        );
    end

    // --- result stage ---
    logic            pend_reg, pend_next;
    logic            out_free, capture, sel_hit;
    tssf_pkg::link_t sel_link;
    logic            m_valid_reg, m_valid_next;
    tssf_pkg::row_t  srow_reg, srow_next;
    tssf_pkg::col_t  scol_reg, scol_next;
    tssf_pkg::row_t  erow_reg, erow_next;
    tssf_pkg::ecol_t ecol_reg, ecol_next;
    tssf_pkg::cnt_t  num_reg, num_next;
    tssf_pkg::cnt_t  cnt_reg, cnt_next;

    assign out_free = !m_valid_reg || m_ready;
    assign capture  = pend_reg && out_free;
    assign sel_link = links[int'(sel_reg) + 1];
    assign sel_hit  = len_nz_reg && sel_link.hit;
    assign s_ready  = !pend_reg || out_free;

    always_comb begin
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        srow_next    = srow_reg;
        scol_next    = scol_reg;
        erow_next    = erow_reg;
        ecol_next    = ecol_reg;
        num_next     = num_reg;
        cnt_next     = cnt_reg;

        if (capture) begin
            m_valid_next = sel_hit;
            srow_next    = sel_link.start_row;
            scol_next    = sel_link.start_col;
            erow_next    = last_row_reg;
            ecol_next    = {1'b0, last_col_reg} + 11'd1;
            num_next     = cnt_reg;
            if (sel_hit && (cnt_reg != '1)) begin
                cnt_next = cnt_reg + 16'd1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // restart lands after any match selected at the same edge
        if (restart_acc) begin
            cnt_next = '0;
        end

        if (text_acc) begin
            pend_next = 1'b1;
        end else if (out_free) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg     <= '0;
            len_nz_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            sel_reg     <= sel_next;
            len_nz_reg  <= len_nz_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_row_reg <= last_row_next;
        last_col_reg <= last_col_next;
        srow_reg     <= srow_next;
        scol_reg     <= scol_next;
        erow_reg     <= erow_next;
        ecol_reg     <= ecol_next;
        num_reg      <= num_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_start_row    = srow_reg;
    assign m_start_col    = scol_reg;
    assign m_end_row      = erow_reg;
    assign m_end_col      = ecol_reg;
    assign m_match_number = num_reg;

`ifndef SYNTHESIS
    // A new result only comes out of a pending selection
    a_valid_from_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(pend_reg))
        else $error("result without a pending text item");

    // Input stalls only behind a held result with a selection waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> pend_reg && m_valid_reg && !m_ready)
        else $error("input stalled without cause");

    // Match count moves only on a delivered match or a restart
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != $past(cnt_reg)) |-> $past(restart_acc) || $past(capture && sel_hit))
        else $error("match count changed unexpectedly");

    // End column is one past a real column
    a_end_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (ecol_reg != '0))
        else $error("end column is zero");
`endif

endmodule
